/* sv/xse_pkg.sv */
// Package for the x86 subset execute unit: opcodes, operand modes,
// sizes and the effective address function. No dependencies.
`default_nettype none
package xse_pkg;

    // opcodes
    localparam logic [2:0] OP_MOV  = 3'd0;
    localparam logic [2:0] OP_PUSH = 3'd1;
    localparam logic [2:0] OP_POP  = 3'd2;
    localparam logic [2:0] OP_CALL = 3'd3;
    localparam logic [2:0] OP_RET  = 3'd4;
    localparam logic [2:0] OP_ADD  = 3'd5;
    localparam logic [2:0] OP_SUB  = 3'd6;

    // operand modes
    localparam logic [3:0] MODE_EMPTY  = 4'd0;
    localparam logic [3:0] MODE_IMM    = 4'd1;
    localparam logic [3:0] MODE_REG    = 4'd2;
    localparam logic [3:0] MODE_MEMLO  = 4'd3;
    localparam logic [3:0] MODE_BIDX   = 4'd6;
    localparam logic [3:0] MODE_IBIDX  = 4'd7;
    localparam logic [3:0] MODE_SIDX   = 4'd8;
    localparam logic [3:0] MODE_ISIDX  = 4'd9;
    localparam logic [3:0] MODE_BSIDX  = 4'd10;
    localparam logic [3:0] MODE_MEMHI  = 4'd11;
    localparam logic [3:0] MODE_BASE   = 4'd4;
    localparam logic [3:0] MODE_IBASE  = 4'd5;

    // config register indexes
    localparam logic [1:0] CFG_START_PC    = 2'd0;
    localparam logic [1:0] CFG_START_STACK = 2'd1;
    localparam logic [1:0] CFG_INSTR_LEN   = 2'd2;

    localparam int          MEM_WORDS_DEF = 1024;
    localparam int          NUM_REGS_DEF  = 16;
    localparam logic [3:0]  SP_REG        = 4'd4;
    localparam logic [63:0] SLOT_BYTES    = 64'd8;
    localparam int          SIGN_POS      = 63;
    localparam logic [7:0]  INSTR_LEN_RST = 8'd64;

    localparam int IN_W  = 168;
    localparam int OUT_W = 136;

    function automatic logic is_mem(input logic [3:0] mode);
        is_mem = (mode >= MODE_MEMLO) && (mode <= MODE_MEMHI);
    endfunction

    // imm + base + index * scale, by addressing form
    function automatic logic [63:0] eff_addr(input logic [3:0] mode,
                                             input logic [63:0] imm,
                                             input logic [63:0] b,
                                             input logic [63:0] x,
                                             input logic [3:0] scale);
        logic [67:0] xs_full;
        logic [63:0] xs;
        xs_full = x * {64'd0, scale};
        xs = xs_full[63:0];
        unique case (mode)
            MODE_MEMLO: eff_addr = imm;
            MODE_BASE:  eff_addr = b;
            MODE_IBASE: eff_addr = imm + b;
            MODE_BIDX:  eff_addr = b + x;
            MODE_IBIDX: eff_addr = imm + b + x;
            MODE_SIDX:  eff_addr = xs;
            MODE_ISIDX: eff_addr = imm + xs;
            MODE_BSIDX: eff_addr = b + xs;
            MODE_MEMHI: eff_addr = imm + b + xs;
            default:    eff_addr = 64'd0;
        endcase
    endfunction

endpackage
`default_nettype wire

/* sv/xse_dmem.sv */
// Data memory of the execute unit: one write port, one read port with
// registered read data. Uses xse_pkg.
`default_nettype none
module xse_dmem #(
    parameter int MEM_WORDS = xse_pkg::MEM_WORDS_DEF,
    parameter int AW        = $clog2(MEM_WORDS)
) (
    input  wire logic          aclk,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic [63:0]        rd_data,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [63:0]   wr_data
);
    import xse_pkg::*;

    logic [63:0] mem [MEM_WORDS];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered read data
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

/* sv/x86_subset_execute_unit.sv */
// Top level of the x86 subset execute unit: decode, register file,
// commit and output register. Uses xse_pkg and xse_dmem.
//
//  channel  dir  ports                               word
//  s_       in   s_tvalid s_tready s_tdata[167:0]     one decoded instruction
//  m_       out  m_tvalid m_tready m_tdata[135:0]     status, pc, flags, value
//  apb      in   psel penable pwrite paddr pwdata ... start_pc/stack, instr_len
//
// An instruction is accepted, which reads registers and issues the data memory
// read, and is then committed from the decoded word register. A new word is
// not accepted until the previous one has committed.
// Reset (aresetn low, synchronous) clears registers, pc, flags; memory is
// undefined until written. A full output register stalls the commit, and the
// word held for commit keeps s_tready low until it drains.
`default_nettype none
module x86_subset_execute_unit #(
    parameter int MEM_WORDS = xse_pkg::MEM_WORDS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // req_type, src_mode, src_imm, src_base, src_index, src_scale,
    // dst_mode, dst_imm, dst_base, dst_index, dst_scale, zero fill
    input  wire logic [xse_pkg::IN_W-1:0]  s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // status, next_pc, flag_bits, written_value, zero fill
    output logic [xse_pkg::OUT_W-1:0]  m_tdata,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [4:0]            paddr,
    input  wire logic [63:0]           pwdata,
    output logic [63:0]                prdata,
    output logic                       pready
);
    import xse_pkg::*;

    localparam int AW = $clog2(MEM_WORDS);

    // decoded work held between accept and commit
    typedef struct packed {
        logic          ok;
        logic          sp_we;
        logic [63:0]   sp_val;
        logic          gp_we;
        logic [3:0]    gp_idx;
        logic          wv_mem;
        logic [63:0]   wv;
        logic          pc_mem;
        logic [63:0]   pc_val;
        logic [3:0]    flg;
        logic          mem_we;
        logic [AW-1:0] mem_idx;
    } s1_t;

    logic [63:0] rf_reg [16];
    logic [63:0] pc_reg, start_pc_reg, start_stack_reg;
    logic [7:0]  instr_len_reg;
    logic [3:0]  flags_reg;
    logic        s1_valid_reg;
    s1_t         s1_reg, s1_next;
    logic        m_valid_reg;
    logic [OUT_W-1:0] m_data_reg;

    // input fields
    logic [2:0]  req_type;
    logic [3:0]  src_mode, src_base, src_index, src_scale;
    logic [3:0]  dst_mode, dst_base, dst_index, dst_scale;
    logic [63:0] src_imm, dst_imm;
    assign req_type  = s_tdata[2:0];
    assign src_mode  = s_tdata[6:3];
    assign src_imm   = s_tdata[70:7];
    assign src_base  = s_tdata[74:71];
    assign src_index = s_tdata[78:75];
    assign src_scale = s_tdata[82:79];
    assign dst_mode  = s_tdata[86:83];
    assign dst_imm   = s_tdata[150:87];
    assign dst_base  = s_tdata[154:151];
    assign dst_index = s_tdata[158:155];
    assign dst_scale = s_tdata[162:159];

    logic accept, commit, cfg_wr;
    assign s_tready = !s1_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign commit   = s1_valid_reg && (!m_valid_reg || m_tready);
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;

    // register reads and addresses
    logic [63:0] rs, rdv, sp, ea_s, ea_d, seq, sp_dn, sp_up, add_v, sub_v;
    logic [64:0] add_full;
    logic        rd_en;
    logic [63:0] rd_addr;
    assign rs    = rf_reg[src_base];
    assign rdv   = rf_reg[dst_base];
    assign sp    = rf_reg[SP_REG];
    assign ea_s  = eff_addr(src_mode, src_imm, rs, rf_reg[src_index], src_scale);
    assign ea_d  = eff_addr(dst_mode, dst_imm, rdv, rf_reg[dst_index], dst_scale);
    assign seq   = pc_reg + {56'd0, instr_len_reg};
    assign sp_dn = sp - SLOT_BYTES;
    assign sp_up = sp + SLOT_BYTES;
    assign add_full = {1'b0, rdv} + {1'b0, rs};
    assign add_v = add_full[63:0];
    assign sub_v = rdv - src_imm;

    // decode one instruction
    always_comb begin
        s1_next = '0;
        s1_next.gp_idx = dst_base;
        s1_next.pc_val = seq;
        rd_en   = 1'b0;
        rd_addr = sp;
        unique case (req_type)
            OP_MOV: begin
                if (src_mode == MODE_IMM && dst_mode == MODE_REG) begin
                    s1_next.ok = 1'b1; s1_next.wv = src_imm; s1_next.gp_we = 1'b1;
                end else if (src_mode == MODE_REG && dst_mode == MODE_REG) begin
                    s1_next.ok = 1'b1; s1_next.wv = rs; s1_next.gp_we = 1'b1;
                end else if (src_mode == MODE_REG && is_mem(dst_mode)) begin
                    s1_next.ok = 1'b1; s1_next.wv = rs; s1_next.mem_we = 1'b1;
                    s1_next.mem_idx = ea_d[AW+2:3];
                end else if (is_mem(src_mode) && dst_mode == MODE_REG) begin
                    s1_next.ok = 1'b1; s1_next.wv_mem = 1'b1; s1_next.gp_we = 1'b1;
                    rd_en = 1'b1; rd_addr = ea_s;
                end
            end
            OP_PUSH: begin
                if (src_mode == MODE_REG) begin
                    s1_next.ok = 1'b1; s1_next.wv = rs;
                    s1_next.sp_we = 1'b1; s1_next.sp_val = sp_dn;
                    s1_next.mem_we = 1'b1; s1_next.mem_idx = sp_dn[AW+2:3];
                end
            end
            OP_POP: begin
                if (src_mode == MODE_REG) begin
                    s1_next.ok = 1'b1; s1_next.wv_mem = 1'b1;
                    s1_next.sp_we = 1'b1; s1_next.sp_val = sp_up;
                    s1_next.gp_we = 1'b1; s1_next.gp_idx = src_base;
                    rd_en = 1'b1;
                end
            end
            OP_CALL: begin
                if (src_mode == MODE_IMM || src_mode == MODE_REG || is_mem(src_mode)) begin
                    s1_next.ok = 1'b1; s1_next.wv = seq;
                    s1_next.sp_we = 1'b1; s1_next.sp_val = sp_dn;
                    s1_next.mem_we = 1'b1; s1_next.mem_idx = sp_dn[AW+2:3];
                    s1_next.pc_val = (src_mode == MODE_IMM) ? src_imm :
                                     (src_mode == MODE_REG) ? rs : ea_s;
                end
            end
            OP_RET: begin
                s1_next.ok = 1'b1; s1_next.pc_mem = 1'b1;
                s1_next.sp_we = 1'b1; s1_next.sp_val = sp_up;
                rd_en = 1'b1;
            end
            OP_ADD: begin
                if (src_mode == MODE_REG && dst_mode == MODE_REG) begin
                    s1_next.ok = 1'b1; s1_next.wv = add_v; s1_next.gp_we = 1'b1;
                    s1_next.flg = {(rs[SIGN_POS] == rdv[SIGN_POS]) &&
                                   (add_v[SIGN_POS] != rs[SIGN_POS]),
                                   add_v[SIGN_POS], add_v == 64'd0, add_full[64]};
                end
            end
            OP_SUB: begin
                if (src_mode == MODE_IMM && dst_mode == MODE_REG) begin
                    s1_next.ok = 1'b1; s1_next.wv = sub_v; s1_next.gp_we = 1'b1;
                    s1_next.flg = {(src_imm[SIGN_POS] != rdv[SIGN_POS]) &&
                                   (sub_v[SIGN_POS] != rdv[SIGN_POS]),
                                   sub_v[SIGN_POS], sub_v == 64'd0, rdv < src_imm};
                end
            end
            default: begin
                s1_next.ok = 1'b0;
            end
        endcase
        if (!s1_next.ok) begin
            rd_en = 1'b0;
        end
    end

    logic [63:0] mem_rdata, gp_val, pc_val;
    xse_dmem #(.MEM_WORDS(MEM_WORDS), .AW(AW)) u_dmem (
        .aclk    (aclk),
        .rd_en   (accept && rd_en),
        .rd_addr (rd_addr[AW+2:3]),
        .rd_data (mem_rdata),
        .wr_en   (commit && s1_reg.ok && s1_reg.mem_we),
        .wr_addr (s1_reg.mem_idx),
        .wr_data (s1_reg.wv)
    );

    assign gp_val = s1_reg.wv_mem ? mem_rdata : s1_reg.wv;
    assign pc_val = s1_reg.pc_mem ? mem_rdata : s1_reg.pc_val;

    // register file: config load, stack update, then general write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 16; i++) begin
                rf_reg[i] <= 64'd0;
            end
        end else if (cfg_wr && paddr[4:3] == CFG_START_STACK) begin
            rf_reg[SP_REG] <= pwdata;
        end else if (commit && s1_reg.ok) begin
            if (s1_reg.sp_we) begin
                rf_reg[SP_REG] <= s1_reg.sp_val;
            end
            if (s1_reg.gp_we) begin
                rf_reg[s1_reg.gp_idx] <= gp_val;
            end
        end
    end

    // control, pc, flags, config and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg          <= 64'd0;
            flags_reg       <= 4'd0;
            start_pc_reg    <= 64'd0;
            start_stack_reg <= 64'd0;
            instr_len_reg   <= INSTR_LEN_RST;
            s1_valid_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr) begin
                unique case (paddr[4:3])
                    CFG_START_PC: begin
                        start_pc_reg <= pwdata;
                        pc_reg       <= pwdata;
                    end
                    CFG_START_STACK: start_stack_reg <= pwdata;
                    CFG_INSTR_LEN:   instr_len_reg   <= pwdata[7:0];
                    default: ;
                endcase
            end
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (commit) begin
                s1_valid_reg <= 1'b0;
            end
            if (commit) begin
                m_valid_reg <= 1'b1;
                if (s1_reg.ok) begin
                    pc_reg    <= pc_val;
                    flags_reg <= s1_reg.flg;
                    m_data_reg <= {3'd0, gp_val, s1_reg.flg, pc_val, 1'b0};
                end else begin
                    m_data_reg <= {3'd0, 64'd0, flags_reg, pc_reg, 1'b1};
                end
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // decoded word register
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_reg <= s1_next;
        end
    end

    // config readback
    always_comb begin
        unique case (paddr[4:3])
            CFG_START_PC:    prdata = start_pc_reg;
            CFG_START_STACK: prdata = start_stack_reg;
            CFG_INSTR_LEN:   prdata = {56'd0, instr_len_reg};
            default:         prdata = 64'd0;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // one word in flight between accept and commit
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (s1_valid_reg && !s_tready))
        else $error("second word accepted before commit");

    // every commit yields an output word
    a_commit_out: assert property (@(posedge aclk) disable iff (!aresetn)
        commit |=> m_tvalid)
        else $error("commit without output word");

    // illegal words report no written value
    a_illegal_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |-> (m_tdata[132:69] == 64'd0))
        else $error("illegal word with written value");
endmodule
`default_nettype wire
